/* rtl/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP_FWD   = 3'd4,
    CMD_DUMP_REV   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DATA
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic push;
    logic err;
    logic rd_en;
    logic data_load;
    logic pop_commit;
    logic idx_inc;
  } dq_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_dump;
    logic empty;
    logic full;
    logic out_free;
    logic dump_last;
  } dq_stat_t;

endpackage

/* rtl/dq_in_if.sv */
// Command channel interface.
`timescale 1ns / 1ps
interface dq_in_if;
  import dq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

/* rtl/dq_out_if.sv */
// Result channel interface.
`timescale 1ns / 1ps
interface dq_out_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_value;
  logic [COUNT_W-1:0]       entry_count;
  logic [STAT_W-1:0]        status;
  logic                     last;

  modport source (output valid, output result_value, output entry_count, output status,
                  output last, input ready);
  modport sink   (input valid, input result_value, input entry_count, input status,
                  input last, output ready);
endinterface

/* rtl/dq_ctrl.sv */
// Command sequencer for the double-ended queue.
`timescale 1ns / 1ps
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dq_stat_t stat,
  output logic     in_ready,
  output dq_ctrl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_push) begin
          if (stat.out_free) begin
            state_nxt = ST_IDLE;
          end
        end else if (stat.is_pop || stat.is_dump) begin
          if (stat.empty) begin
            if (stat.out_free) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_DATA;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (stat.out_free) begin
          if (stat.is_dump && !stat.dump_last) begin
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_EXEC: begin
        if (stat.is_push) begin
          ctl.push = stat.out_free && !stat.full;
          ctl.err  = stat.out_free && stat.full;
        end else if (stat.is_pop || stat.is_dump) begin
          ctl.err   = stat.out_free && stat.empty;
          ctl.rd_en = !stat.empty;
        end
      end
      ST_DATA: begin
        ctl.data_load  = stat.out_free;
        ctl.pop_commit = stat.out_free && stat.is_pop;
        ctl.idx_inc    = stat.out_free && stat.is_dump && !stat.dump_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/dq_dpath.sv */
// Ring storage, pointers and result register of the double-ended queue.
`timescale 1ns / 1ps
module dq_dpath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [WORD_W-1:0] in_value,
  input  dq_ctrl_t          ctl,
  output dq_stat_t          stat,
  dq_out_if.source          out_ch
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [WORD_W-1:0] value_r;
  logic [IW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r;
  logic [CW-1:0]     out_count_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic              is_push, is_pop, is_dump, is_front;
  logic [CW-1:0]     count_m1;
  logic [IW-1:0]     off;
  logic [IW:0]       slot_sum;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     front_dec;
  logic [IW-1:0]     front_inc;
  logic [IW-1:0]     wr_addr;

  assign is_push  = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_BACK);
  assign is_pop   = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_POP_BACK);
  assign is_dump  = (cmd_r == CMD_DUMP_FWD) || (cmd_r == CMD_DUMP_REV);
  assign is_front = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_POP_FRONT);
  assign count_m1 = count_r - CW'(1);

  always_comb begin
    case (cmd_r)
      CMD_PUSH_BACK: off = IW'(count_r);
      CMD_POP_FRONT: off = '0;
      CMD_POP_BACK:  off = IW'(count_m1);
      CMD_DUMP_FWD:  off = IW'(idx_r);
      CMD_DUMP_REV:  off = IW'(count_m1 - idx_r);
      default:       off = '0;
    endcase
  end

  assign slot_sum  = {1'b0, front_r} + {1'b0, off};
  assign slot      = (slot_sum >= (IW+1)'(DEPTH)) ? IW'(slot_sum - (IW+1)'(DEPTH))
                                                  : IW'(slot_sum);
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + IW'(1);
  assign wr_addr   = is_front ? front_dec : slot;

  assign stat.is_push   = is_push;
  assign stat.is_pop    = is_pop;
  assign stat.is_dump   = is_dump;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= CW'(DEPTH));
  assign stat.out_free  = !out_valid_r || out_ch.ready;
  assign stat.dump_last = (idx_r == count_m1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= value_r;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
      if (is_front) begin
        front_nxt = front_dec;
      end
    end
    if (ctl.pop_commit) begin
      count_nxt = count_m1;
      if (is_front) begin
        front_nxt = front_inc;
      end
    end
    if (ctl.capture) begin
      idx_nxt = '0;
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.push || ctl.err || ctl.data_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_value_r  <= '0;
      out_count_r  <= count_r + CW'(1);
      out_status_r <= STAT_OK;
      out_last_r   <= 1'b1;
    end else if (ctl.err) begin
      out_value_r  <= '0;
      out_count_r  <= count_r;
      out_status_r <= is_push ? STAT_FULL : STAT_EMPTY;
      out_last_r   <= 1'b1;
    end else if (ctl.data_load) begin
      out_value_r  <= rd_data_r;
      out_count_r  <= is_pop ? count_m1 : count_r;
      out_status_r <= STAT_OK;
      out_last_r   <= !is_dump || (idx_r == count_m1);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.entry_count  = COUNT_W'(out_count_r);
  assign out_ch.status       = out_status_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IW'(DEPTH - 1))
    else $error("front index out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push || ctl.err || ctl.data_load) |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before transfer");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not advance count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop_commit |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not reduce count");
`endif

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the bounded double-ended queue.
// Push, or any error result: the result register loads from EXEC once it is free.
// Pop: the ring read is registered in EXEC first, then the result loads in DATA.
// Dump: each word is read from the ring in EXEC, then loaded in DATA, forward or reverse.
// The next command is taken only in IDLE, after the last load; a loaded result that waits
// for the receiver holds off the next load, and so the next command.
// Synchronous active-low reset empties the queue; ring contents are not cleared.
`timescale 1ns / 1ps
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  dq_ctrl_t ctl;
  dq_stat_t stat;
  logic     in_ready;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_ch.command),
    .in_value   (in_ch.value),
    .ctl        (ctl),
    .stat       (stat),
    .out_ch     (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

/* tb/double_ended_queue_tb.sv */
// Self-checking testbench for the double-ended queue: random and directed commands, predicted results.
`timescale 1ns / 1ps
module double_ended_queue_tb
  import dq_pkg::*;
();

  localparam int unsigned DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [COUNT_W-1:0]       count;
    status_t                  status;
    logic                     last;
  } dq_result_t;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] word;
    bit                       drain;
  } dq_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  dq_item_t   cmd_queue [$];
  dq_result_t due_results [$];

  // predicted deque contents
  logic signed [WORD_W-1:0] ring [DEPTH];
  int unsigned head_idx = 0;
  int unsigned fill = 0;

  int gen_fill = 0;
  int stim_count = 0;
  int total_items = 0;
  int accepted = 0;
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic expect_result(input logic signed [WORD_W-1:0] word, input status_t status,
                               input logic last);
    dq_result_t r;
    r.word   = word;
    r.count  = fill[COUNT_W-1:0];
    r.status = status;
    r.last   = last;
    due_results.push_back(r);
  endtask

  task automatic advance_deque(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] word);
    int unsigned off;
    logic signed [WORD_W-1:0] popped;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          expect_result('0, STAT_FULL, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring[head_idx] = word;
          end else begin
            ring[(head_idx + fill) % DEPTH] = word;
          end
          fill++;
          expect_result('0, STAT_OK, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          expect_result('0, STAT_EMPTY, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            popped = ring[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            popped = ring[(head_idx + fill - 1) % DEPTH];
          end
          fill--;
          expect_result(popped, STAT_OK, 1'b1);
        end
      end
      CMD_DUMP_FWD, CMD_DUMP_REV: begin
        if (fill == 0) begin
          expect_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++) begin
            off = (cmd == CMD_DUMP_FWD) ? i : fill - 1 - i;
            expect_result(ring[(head_idx + off) % DEPTH], STAT_OK, i + 1 == fill);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] word,
                           input bit drain);
    dq_item_t it;
    it.cmd   = cmd;
    it.word  = word;
    it.drain = drain;
    cmd_queue.push_back(it);
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
      CMD_POP_FRONT, CMD_POP_BACK: if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
    if (cmd <= CMD_DUMP_REV) stim_count++;
  endtask

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_push();
    return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
  endfunction

  function automatic logic [CMD_W-1:0] rand_pop();
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  function automatic logic [CMD_W-1:0] rand_dump();
    return $urandom_range(0, 1) ? CMD_DUMP_REV : CMD_DUMP_FWD;
  endfunction

  function automatic int idle_phase();
    if (accepted * 3 < total_items) return 0;
    if (accepted * 3 < total_items * 2) return 1;
    return 2;
  endfunction

  // stimulus
  initial begin
    int seg;
    int r;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;

    queue_cmd(CMD_POP_FRONT, rand_word(), 1'b0);
    queue_cmd(CMD_POP_BACK, rand_word(), 1'b0);
    queue_cmd(CMD_DUMP_FWD, rand_word(), 1'b0);
    queue_cmd(CMD_DUMP_REV, rand_word(), 1'b0);
    queue_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff, 1'b0);
    queue_cmd(CMD_PUSH_BACK, 32'sh8000_0000, 1'b0);
    queue_cmd(CMD_PUSH_FRONT, -32'sd1, 1'b0);
    queue_cmd(CMD_PUSH_BACK, '0, 1'b0);
    queue_cmd(CMD_PUSH_FRONT, 32'sh5555_5555, 1'b0);
    queue_cmd(CMD_PUSH_BACK, 32'shaaaa_aaaa, 1'b0);
    queue_cmd(CMD_DUMP_FWD, '0, 1'b0);
    queue_cmd(CMD_DUMP_REV, -32'sd1, 1'b0);
    queue_cmd(CMD_SPARE_A, rand_word(), 1'b0);
    queue_cmd(CMD_SPARE_B, rand_word(), 1'b0);
    queue_cmd(CMD_POP_FRONT, '0, 1'b1);
    queue_cmd(CMD_POP_BACK, '0, 1'b0);
    queue_cmd(CMD_POP_FRONT, '0, 1'b0);
    queue_cmd(CMD_POP_BACK, '0, 1'b0);
    queue_cmd(CMD_DUMP_FWD, '0, 1'b0);

    while (stim_count < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg <= 2) begin
        // fill to full, then push into a full queue
        while (gen_fill < DEPTH) queue_cmd(rand_push(), rand_word(), 1'b0);
        repeat ($urandom_range(1, 2)) queue_cmd(rand_push(), rand_word(), 1'b0);
        if ($urandom_range(0, 1)) queue_cmd(rand_dump(), rand_word(), 1'b0);
      end else if (seg <= 4) begin
        while (gen_fill > 0) queue_cmd(rand_pop(), rand_word(), 1'b0);
        queue_cmd($urandom_range(0, 1) ? rand_pop() : rand_dump(), rand_word(), 1'b0);
      end else if (seg <= 8) begin
        repeat ($urandom_range(4, 10)) begin
          r = $urandom_range(0, 99);
          if (r < 40) queue_cmd(rand_push(), rand_word(), $urandom_range(0, 39) == 0);
          else if (r < 70) queue_cmd(rand_pop(), rand_word(), 1'b0);
          else if (r < 88) queue_cmd(rand_dump(), rand_word(), 1'b0);
          else queue_cmd($urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A, rand_word(), 1'b0);
        end
      end else begin
        queue_cmd(CMD_DUMP_FWD, rand_word(), 1'b0);
        queue_cmd(CMD_DUMP_REV, rand_word(), 1'b0);
      end
    end
    total_items = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // command driver
  always @(posedge clk) begin : driver
    logic offer;
    int idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        advance_deque(in_ch.command, in_ch.value);
        void'(cmd_queue.pop_front());
        accepted++;
        offer = 1'b0;
      end
      case (idle_phase())
        0: idle_pct = 34;
        1: idle_pct = 74;
        default: idle_pct = 0;
      endcase
      if (!offer && cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
          (!cmd_queue[0].drain || due_results.size() == 0)) begin
        offer = 1'b1;
        in_ch.command <= cmd_queue[0].cmd;
        in_ch.value   <= cmd_queue[0].word;
      end
      in_ch.valid <= offer;
    end
  end

  // long receiver hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= 60) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    dq_result_t exp_r;
    int idle_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transfer: value %0d count %0d status %0d last %0d",
                 out_ch.result_value, out_ch.entry_count, out_ch.status, out_ch.last);
          errors++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_ch.result_value !== exp_r.word) begin
            $error("result_value: expected %0d, got %0d", exp_r.word, out_ch.result_value);
            errors++;
          end
          if (out_ch.entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, out_ch.entry_count);
            errors++;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
            errors++;
          end
          if (out_ch.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_ch.last);
            errors++;
          end
        end
      end
      case (idle_phase())
        0: idle_pct = 74;
        1: idle_pct = 34;
        default: idle_pct = 0;
      endcase
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
